FILE: rtl/map_pixel_to_occupancy_macros.svh
// Assertion macros shared by the pixel-to-occupancy RTL.
`ifndef MAP_PIXEL_TO_OCCUPANCY_MACROS_SVH
`define MAP_PIXEL_TO_OCCUPANCY_MACROS_SVH

// Same-cycle implication, clocked by clk_i, quiet while rst_ni is low.
`define MPO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, clocked by clk_i, quiet while rst_ni is low.
`define MPO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: rtl/mpo_pkg.sv
// Types, constants and register codes of the pixel-to-occupancy block.
package mpo_pkg;

  localparam int PixW     = 8;
  localparam int CoordW   = 12;
  localparam int DimW     = 13;
  localparam int ThrW     = 16;
  localparam int ModeW    = 2;
  localparam int OccW     = 8;
  localparam int CellW    = 24;
  localparam int ProdW    = 24;
  localparam int NumW     = 32;
  localparam int Num99W   = NumW - 1;
  localparam int DenW     = ProdW + 1;
  localparam int QuotW    = 7;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int MaxDim   = 4096;

  localparam int ScaleGain = 99;
  localparam int RawGain   = 200;

  localparam logic [OccW-1:0] OccOccupied = OccW'(100);
  localparam logic [OccW-1:0] OccFree     = OccW'(0);
  localparam logic [OccW-1:0] OccUnknown  = '1;
  localparam logic [OccW-1:0] OccZeroSpan = OccW'(1);
  localparam logic [QuotW-1:0] ScaleMin   = QuotW'(1);
  localparam logic [QuotW-1:0] ScaleMax   = QuotW'(99);
  localparam logic [QuotW-1:0] RawMax     = QuotW'(100);

  typedef enum logic [ModeW-1:0] {
    MODE_TRINARY = 2'd0,
    MODE_SCALE   = 2'd1,
    MODE_RAW     = 2'd2
  } mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MODE     = 3'd0,
    REG_INVERT   = 3'd1,
    REG_OCC_THR  = 3'd2,
    REG_FREE_THR = 3'd3,
    REG_PIX_MAX  = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             invert;
    logic [ThrW-1:0]  occ_thr;
    logic [ThrW-1:0]  free_thr;
    logic [PixW-1:0]  pix_max;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    mode:     MODE_TRINARY,
    invert:   1'b0,
    occ_thr:  ThrW'(42598),
    free_thr: ThrW'(12845),
    pix_max:  PixW'(255),
    width:    DimW'(MaxDim),
    height:   DimW'(MaxDim)
  };

  // Decision flags and destination cell that ride alongside the divider.
  typedef struct packed {
    logic             above;
    logic             below;
    logic             span_zero;
    logic [CellW-1:0] cell_index;
  } side_t;

endpackage

FILE: rtl/mpo_cfg.sv
// Configuration register file with dimension saturation.
module mpo_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpo_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mpo_pkg::CfgDataW-1:0] cfg_data_i,
  output mpo_pkg::cfg_t                cfg_o
);
  import mpo_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic [DimW-1:0]  dim_raw;
  logic [DimW-1:0]  dim_sat;

  assign dim_raw = cfg_data_i[DimW-1:0];
  assign dim_sat = (dim_raw > DimW'(MaxDim)) ? DimW'(MaxDim) : dim_raw;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MODE:     cfg_d.mode     = cfg_data_i[ModeW-1:0];
        REG_INVERT:   cfg_d.invert   = cfg_data_i[0];
        REG_OCC_THR:  cfg_d.occ_thr  = cfg_data_i[ThrW-1:0];
        REG_FREE_THR: cfg_d.free_thr = cfg_data_i[ThrW-1:0];
        REG_PIX_MAX:  cfg_d.pix_max  = cfg_data_i[PixW-1:0];
        REG_WIDTH:    cfg_d.width    = dim_sat;
        REG_HEIGHT:   cfg_d.height   = dim_sat;
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/mpo_prep.sv
// Five-stage front end: pixel ratio terms, threshold compares, divider operands, cell index.
`include "map_pixel_to_occupancy_macros.svh"

module mpo_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpo_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [mpo_pkg::PixW-1:0]   pixel_i,
  input  logic [mpo_pkg::CoordW-1:0] col_i,
  input  logic [mpo_pkg::CoordW-1:0] row_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [mpo_pkg::NumW-1:0]   num_o,
  output logic [mpo_pkg::DenW-1:0]   den_o,
  output mpo_pkg::side_t             side_o
);
  import mpo_pkg::*;

  localparam int Stages = 5;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] en;

  // Stage 1: saturated pixel, numerator n, flipped row.
  logic [PixW-1:0]   m_eff, v_sat, n_val;
  logic [PixW-1:0]   s1_m_q, s1_n_q;
  logic [CellW-1:0]  s1_flip_q;
  logic [CoordW-1:0] s1_col_q;

  // Stage 2: threshold products, row offset.
  logic [PixW-1:0]   s2_m_q, s2_n_q;
  logic [ProdW-1:0]  s2_om_q, s2_fm_q;
  logic [CellW-1:0]  s2_prod_q;
  logic [CoordW-1:0] s2_col_q;

  // Stage 3: compares, scale numerator and span.
  logic [ProdW-1:0]  pn;
  logic [PixW-1:0]   s3_m_q, s3_n_q;
  logic [ProdW-1:0]  s3_diff_q;
  logic [ThrW-1:0]   s3_span_q;
  logic              s3_above_q, s3_below_q, s3_zero_q;
  logic [CellW-1:0]  s3_cell_q;

  // Stage 4: scaled numerator and denominator.
  logic [PixW-1:0]   s4_m_q, s4_n_q;
  logic [Num99W-1:0] s4_num99_q;
  logic [ProdW-1:0]  s4_den_q;
  side_t             s4_side_q;

  // Stage 5: divider operands for the selected mode.
  logic [NumW-1:0]   s5_num_q;
  logic [DenW-1:0]   s5_den_q;
  side_t             s5_side_q;

  // Advance a stage when it is empty or its successor advances.
  assign en[Stages-1] = !vld_q[Stages-1] || ready_i;
  for (genvar k = 0; k < Stages - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign m_eff = (cfg_i.pix_max == '0) ? PixW'(1) : cfg_i.pix_max;
  assign v_sat = (pixel_i > m_eff) ? m_eff : pixel_i;
  assign n_val = cfg_i.invert ? v_sat : m_eff - v_sat;
  assign pn    = {s2_n_q, {(ProdW - PixW){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_m_q    <= m_eff;
      s1_n_q    <= n_val;
      s1_flip_q <= CellW'(cfg_i.height) - CellW'(1) - CellW'(row_i);
      s1_col_q  <= col_i;
    end
    if (en[1]) begin
      s2_m_q    <= s1_m_q;
      s2_n_q    <= s1_n_q;
      s2_om_q   <= ProdW'(cfg_i.occ_thr) * ProdW'(s1_m_q);
      s2_fm_q   <= ProdW'(cfg_i.free_thr) * ProdW'(s1_m_q);
      s2_prod_q <= s1_flip_q * CellW'(cfg_i.width);
      s2_col_q  <= s1_col_q;
    end
    if (en[2]) begin
      s3_m_q     <= s2_m_q;
      s3_n_q     <= s2_n_q;
      s3_above_q <= pn > s2_om_q;
      s3_below_q <= pn < s2_fm_q;
      s3_zero_q  <= cfg_i.occ_thr <= cfg_i.free_thr;
      s3_diff_q  <= pn - s2_fm_q;
      s3_span_q  <= cfg_i.occ_thr - cfg_i.free_thr;
      s3_cell_q  <= s2_prod_q + CellW'(s2_col_q);
    end
    if (en[3]) begin
      s4_m_q               <= s3_m_q;
      s4_n_q               <= s3_n_q;
      s4_num99_q           <= Num99W'(s3_diff_q) * Num99W'(ScaleGain);
      s4_den_q             <= ProdW'(s3_m_q) * ProdW'(s3_span_q);
      s4_side_q.above      <= s3_above_q;
      s4_side_q.below      <= s3_below_q;
      s4_side_q.span_zero  <= s3_zero_q;
      s4_side_q.cell_index <= s3_cell_q;
    end
    if (en[4]) begin
      if (cfg_i.mode == MODE_RAW) begin
        // Round half up: (200 n + m) / (2 m).
        s5_num_q <= NumW'(s4_n_q) * NumW'(RawGain) + NumW'(s4_m_q);
        s5_den_q <= DenW'({s4_m_q, 1'b0});
      end else begin
        // Round half up: (2 num + den) / (2 den).
        s5_num_q <= {s4_num99_q, 1'b0} + NumW'(s4_den_q);
        s5_den_q <= {s4_den_q, 1'b0};
      end
      s5_side_q <= s4_side_q;
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[Stages-1];
  assign num_o   = s5_num_q;
  assign den_o   = s5_den_q;
  assign side_o  = s5_side_q;

  `MPO_ASSERT_IMPL(a_prep_full_stall, (&vld_q) && !ready_i, !ready_o)
  `MPO_ASSERT_IMPL(a_prep_bubble_ready, !vld_q[0], ready_o)

endmodule

FILE: rtl/mpo_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`include "map_pixel_to_occupancy_macros.svh"

module mpo_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [mpo_pkg::NumW-1:0]  num_i,
  input  logic [mpo_pkg::DenW-1:0]  den_i,
  input  mpo_pkg::side_t            side_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [mpo_pkg::QuotW-1:0] quot_o,
  output mpo_pkg::side_t            side_o
);
  import mpo_pkg::*;

  localparam int DshW = NumW + 1;

  logic [QuotW-1:0] vld_q;
  logic [QuotW-1:0] en;

  logic [NumW-1:0]  rem_q  [QuotW];
  logic [DenW-1:0]  den_q  [QuotW];
  logic [QuotW-1:0] quot_q [QuotW];
  side_t            side_q [QuotW];

  logic [NumW-1:0]  rem_in  [QuotW];
  logic [DenW-1:0]  den_in  [QuotW];
  logic [QuotW-1:0] quot_in [QuotW];
  side_t            side_in [QuotW];
  logic [QuotW-1:0] vld_in;

  for (genvar j = 0; j < QuotW; j++) begin : g_stage
    localparam int K = QuotW - 1 - j;

    logic [DshW-1:0] dsh;
    logic            take;

    if (j == 0) begin : g_first
      assign rem_in[j]  = num_i;
      assign den_in[j]  = den_i;
      assign quot_in[j] = '0;
      assign side_in[j] = side_i;
      assign vld_in[j]  = valid_i;
    end else begin : g_next
      assign rem_in[j]  = rem_q[j-1];
      assign den_in[j]  = den_q[j-1];
      assign quot_in[j] = quot_q[j-1];
      assign side_in[j] = side_q[j-1];
      assign vld_in[j]  = vld_q[j-1];
    end

    if (j == QuotW - 1) begin : g_en_last
      assign en[j] = !vld_q[j] || ready_i;
    end else begin : g_en_mid
      assign en[j] = !vld_q[j] || en[j+1];
    end

    // Trial subtract of the divisor aligned to quotient bit K.
    assign dsh  = DshW'(den_in[j]) << K;
    assign take = {1'b0, rem_in[j]} >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en[j]) begin
        vld_q[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        rem_q[j]     <= take ? rem_in[j] - dsh[NumW-1:0] : rem_in[j];
        den_q[j]     <= den_in[j];
        quot_q[j]    <= quot_in[j] | (QuotW'(take) << K);
        side_q[j]    <= side_in[j];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[QuotW-1];
  assign quot_o  = quot_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

  `MPO_ASSERT_IMPL(a_div_full_stall, (&vld_q) && !ready_i, !ready_o)
  `MPO_ASSERT_NEXT(a_div_hold, valid_o && !ready_i,
                   valid_o && $stable(quot_o) && $stable(side_o))

endmodule

FILE: rtl/map_pixel_to_occupancy.sv
// Top level: pixel to occupancy-grid cell converter with stream ports.
// Usage
//   Slave stream s_axis carries one map pixel per transaction: gray value,
//   source column and source row (top row zero). Master stream m_axis
//   returns exactly one transaction per input: the occupancy value
//   (-1 unknown, 0 free, 1..99 partial, 100 occupied) and the grid index
//   of the vertically flipped cell, (height - 1 - row) * width + column,
//   wrapped to 24 bits.
//   The cfg port writes one register per cycle with cfg_we_i high; write
//   it only while no transaction is in flight.
// Timing
//   Thirteen register stages: five front-end stages (multiplies, compares,
//   divider operands), seven divider stages that each resolve one quotient
//   bit, and the output register. One pixel per cycle is sustained while
//   m_axis_tready stays high.
// Reset and stall
//   rst_ni clears every stage valid bit and loads the register defaults.
//   Each stage advances while it is empty or its successor advances, so a
//   stalled receiver holds its result while bubbles upstream still fill;
//   s_axis_tready drops only when every stage holds a transaction.
module map_pixel_to_occupancy (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // pixel_value, src_column, src_row
  // Master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // occupancy, cell_index
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [mpo_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [mpo_pkg::CfgDataW-1:0] cfg_data_i
);
  import mpo_pkg::*;

  cfg_t             cfg;

  logic             prep_valid, prep_ready;
  logic [NumW-1:0]  prep_num;
  logic [DenW-1:0]  prep_den;
  side_t            prep_side;

  logic             div_valid, div_ready;
  logic [QuotW-1:0] div_quot;
  side_t            div_side;

  logic             out_valid_q;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [CellW-1:0] cell_q;
  logic             out_en;

  mpo_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mpo_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pixel_i (s_axis_tdata[PixW-1:0]),
    .col_i   (s_axis_tdata[PixW+CoordW-1:PixW]),
    .row_i   (s_axis_tdata[PixW+2*CoordW-1:PixW+CoordW]),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .num_o   (prep_num),
    .den_o   (prep_den),
    .side_o  (prep_side)
  );

  mpo_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .num_i   (prep_num),
    .den_i   (prep_den),
    .side_i  (prep_side),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  // Output register loads whenever it is empty or being drained.
  assign out_en    = !out_valid_q || m_axis_tready;
  assign div_ready = out_en;

  // Pick the occupancy code for the configured mode.
  always_comb begin
    occ_d = OccUnknown;
    unique case (cfg.mode)
      MODE_TRINARY: begin
        if (div_side.above)      occ_d = OccOccupied;
        else if (div_side.below) occ_d = OccFree;
        else                     occ_d = OccUnknown;
      end
      MODE_SCALE: begin
        if (div_side.above)          occ_d = OccOccupied;
        else if (div_side.below)     occ_d = OccFree;
        else if (div_side.span_zero) occ_d = OccZeroSpan;
        else if (div_quot < ScaleMin) occ_d = OccW'(ScaleMin);
        else if (div_quot > ScaleMax) occ_d = OccW'(ScaleMax);
        else                         occ_d = OccW'(div_quot);
      end
      MODE_RAW: begin
        occ_d = (div_quot > RawMax) ? OccW'(RawMax) : OccW'(div_quot);
      end
      default: occ_d = OccUnknown;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= div_valid;
    end
  end

  // Hold payload while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      occ_q  <= occ_d;
      cell_q <= div_side.cell_index;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {cell_q, occ_q};

  `MPO_ASSERT_IMPL(a_occ_range, m_axis_tvalid,
                   ($signed(occ_q) >= -8'sd1) && ($signed(occ_q) <= 8'sd100))
  `MPO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(occ_q) && $stable(cell_q))

endmodule
